FILE: src/segint_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segint_pkg
// Shared constants for the segment intersection core.
// ----------------------------------------------------------------------------
package segint_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;

endpackage
`default_nettype wire

FILE: src/segint_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segint_div
// Pipelined restoring divider, one quotient bit per stage. Two numerators
// share one denominator; a tag and a valid bit travel alongside.
// ----------------------------------------------------------------------------
module segint_div #(
  parameter int NW  = 50,
  parameter int DWD = 34,
  parameter int QW  = 17,
  parameter int TW  = 36
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_vld,
  input  wire logic [NW-1:0]  in_nx,
  input  wire logic [NW-1:0]  in_ny,
  input  wire logic [DWD-1:0] in_den,
  input  wire logic [TW-1:0]  in_tag,
  output logic                out_vld,
  output logic [QW-1:0]       out_qx,
  output logic [QW-1:0]       out_qy,
  output logic [TW-1:0]       out_tag
);

  logic [NW-1:0]  rx  [0:QW-1];
  logic [NW-1:0]  ry  [0:QW-1];
  logic [QW-1:0]  qx  [0:QW-1];
  logic [QW-1:0]  qy  [0:QW-1];
  logic [DWD-1:0] den [0:QW-1];
  logic [TW-1:0]  tag [0:QW-1];
  logic [QW-1:0]  vld;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [NW-1:0]  prx, pry;
    logic [QW-1:0]  pqx, pqy;
    logic [DWD-1:0] pden;
    logic [TW-1:0]  ptag;
    logic           pvld;
    logic [NW:0]    dsh;
    logic [NW:0]    tx, ty;

    if (k == 0) begin : g_first
      assign prx  = in_nx;
      assign pry  = in_ny;
      assign pqx  = '0;
      assign pqy  = '0;
      assign pden = in_den;
      assign ptag = in_tag;
      assign pvld = in_vld;
    end else begin : g_next
      assign prx  = rx[k-1];
      assign pry  = ry[k-1];
      assign pqx  = qx[k-1];
      assign pqy  = qy[k-1];
      assign pden = den[k-1];
      assign ptag = tag[k-1];
      assign pvld = vld[k-1];
    end

    assign dsh = {{(NW+1-DWD){1'b0}}, pden} << SH;
    assign tx  = {1'b0, prx} - dsh;
    assign ty  = {1'b0, pry} - dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pvld;
      end
      rx[k]  <= tx[NW] ? prx : tx[NW-1:0];
      ry[k]  <= ty[NW] ? pry : ty[NW-1:0];
      qx[k]  <= {pqx[QW-2:0], ~tx[NW]};
      qy[k]  <= {pqy[QW-2:0], ~ty[NW]};
      den[k] <= pden;
      tag[k] <= ptag;
    end
  end

  assign out_vld = vld[QW-1];
  assign out_qx  = qx[QW-1];
  assign out_qy  = qy[QW-1];
  assign out_tag = tag[QW-1];

endmodule
`default_nettype wire

FILE: src/segment_intersection_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_core
// 2-D segment intersection AB x CD on signed fixed-point coordinates.
//
// Channel   Ports                                  Transfer
// input     start, busy, mode, ax..dy              start && !busy
// result    done, status, sx, sy                   done (one cycle, no stall)
//
// One item per cycle, every cycle; busy is always low.
// Path from transfer to done: six arithmetic
// stages, one divider stage per quotient bit (COORD_WIDTH + 1), one output
// register. Synchronous reset clears every valid bit; data regs are free.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module segment_intersection_core #(
  parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode,
  input  wire logic signed [COORD_WIDTH-1:0] ax,
  input  wire logic signed [COORD_WIDTH-1:0] ay,
  input  wire logic signed [COORD_WIDTH-1:0] bx,
  input  wire logic signed [COORD_WIDTH-1:0] by_coord,
  input  wire logic signed [COORD_WIDTH-1:0] cx,
  input  wire logic signed [COORD_WIDTH-1:0] cy,
  input  wire logic signed [COORD_WIDTH-1:0] dx,
  input  wire logic signed [COORD_WIDTH-1:0] dy,
  output logic                               done,
  output logic [1:0]                         status,
  output logic signed [COORD_WIDTH-1:0]      sx,
  output logic signed [COORD_WIDTH-1:0]      sy
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;          // coordinate differences
  localparam int PW   = 2 * DW;         // pair products
  localparam int DETW = PW + 1;         // det, tn, un
  localparam int DWD  = DETW - 1;       // |det| magnitude
  localparam int PRW  = DETW + DW;      // tn * e
  localparam int NW   = 3 * W + 2;      // |tn * e| on a hit
  localparam int QW   = W + 1;          // quotient magnitude
  localparam int TW   = 4 + 2 * W;      // status, signs, ax, ay
  localparam int LAT  = QW + 7;

  assign busy = 1'b0;

  wire accept = start && !busy;

  // stage 1: differences
  logic                 v1, mode1;
  logic signed [W-1:0]  ax1, ay1;
  logic signed [DW-1:0] ex1, ey1, fx1, fy1, vx1, vy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    mode1 <= mode;
    ax1   <= ax;
    ay1   <= ay;
    ex1   <= DW'(bx) - DW'(ax);
    ey1   <= DW'(by_coord) - DW'(ay);
    fx1   <= DW'(cx) - DW'(dx);
    fy1   <= DW'(cy) - DW'(dy);
    vx1   <= DW'(cx) - DW'(ax);
    vy1   <= DW'(cy) - DW'(ay);
  end

  // stage 2: six products
  logic                 v2, mode2;
  logic signed [W-1:0]  ax2, ay2;
  logic signed [DW-1:0] ex2, ey2;
  logic signed [PW-1:0] m_exfy, m_eyfx, m_fyvx, m_fxvy, m_exvy, m_eyvx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    mode2  <= mode1;
    ax2    <= ax1;
    ay2    <= ay1;
    ex2    <= ex1;
    ey2    <= ey1;
    m_exfy <= PW'(ex1) * PW'(fy1);
    m_eyfx <= PW'(ey1) * PW'(fx1);
    m_fyvx <= PW'(fy1) * PW'(vx1);
    m_fxvy <= PW'(fx1) * PW'(vy1);
    m_exvy <= PW'(ex1) * PW'(vy1);
    m_eyvx <= PW'(ey1) * PW'(vx1);
  end

  // stage 3: det and numerators
  logic                   v3, mode3;
  logic signed [W-1:0]    ax3, ay3;
  logic signed [DW-1:0]   ex3, ey3;
  logic signed [DETW-1:0] det3, tn3, un3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    mode3 <= mode2;
    ax3   <= ax2;
    ay3   <= ay2;
    ex3   <= ex2;
    ey3   <= ey2;
    det3  <= DETW'(m_exfy) - DETW'(m_eyfx);
    tn3   <= DETW'(m_fyvx) - DETW'(m_fxvy);
    un3   <= DETW'(m_exvy) - DETW'(m_eyvx);
  end

  // stage 4: fold sign of det into all three
  logic                   v4, mode4, zero4;
  logic signed [W-1:0]    ax4, ay4;
  logic signed [DW-1:0]   ex4, ey4;
  logic signed [DETW-1:0] det4, tn4, un4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    mode4 <= mode3;
    ax4   <= ax3;
    ay4   <= ay3;
    ex4   <= ex3;
    ey4   <= ey3;
    zero4 <= (det3 == '0);
    det4  <= det3[DETW-1] ? -det3 : det3;
    tn4   <= det3[DETW-1] ? -tn3  : tn3;
    un4   <= det3[DETW-1] ? -un3  : un3;
  end

  // stage 5: interval test, numerator products
  logic                   in_t, in_u;
  logic [1:0]             st4;

  always_comb begin
    if (mode4) begin
      in_t = (tn4 >= 0) && (tn4 <= det4);
      in_u = (un4 >= 0) && (un4 <= det4);
    end else begin
      in_t = (tn4 > 0) && (tn4 < det4);
      in_u = (un4 > 0) && (un4 < det4);
    end
    if (zero4) begin
      st4 = segint_pkg::ST_PARALLEL;
    end else if (in_t && in_u) begin
      st4 = segint_pkg::ST_HIT;
    end else begin
      st4 = segint_pkg::ST_MISS;
    end
  end

  logic                   v5;
  logic [1:0]             st5;
  logic signed [W-1:0]    ax5, ay5;
  logic signed [DETW-1:0] det5;
  logic signed [PRW-1:0]  px5, py5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    st5  <= st4;
    ax5  <= ax4;
    ay5  <= ay4;
    det5 <= det4;
    px5  <= PRW'(tn4) * PRW'(ex4);
    py5  <= PRW'(tn4) * PRW'(ey4);
  end

  // stage 6: magnitudes for the divider
  logic [PRW-1:0] pxa, pya;

  always_comb begin
    pxa = px5[PRW-1] ? -px5 : px5;
    pya = py5[PRW-1] ? -py5 : py5;
  end

  logic            v6;
  logic [NW-1:0]   nx6, ny6;
  logic [DWD-1:0]  den6;
  logic [TW-1:0]   tag6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    nx6  <= pxa[NW-1:0];
    ny6  <= pya[NW-1:0];
    den6 <= det5[DWD-1:0];
    tag6 <= {st5, px5[PRW-1], py5[PRW-1], ax5, ay5};
  end

  // divider: |tn*e| / |det|, truncation toward zero by sign restore
  logic          vq;
  logic [QW-1:0] qx, qy;
  logic [TW-1:0] tagq;

  segint_div #(
    .NW  (NW),
    .DWD (DWD),
    .QW  (QW),
    .TW  (TW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v6),
    .in_nx   (nx6),
    .in_ny   (ny6),
    .in_den  (den6),
    .in_tag  (tag6),
    .out_vld (vq),
    .out_qx  (qx),
    .out_qy  (qy),
    .out_tag (tagq)
  );

  // output: A + signed quotient, point zeroed off a hit
  logic [1:0]     stq;
  logic           negx, negy;
  logic [W-1:0]   axq, ayq;
  logic [W+1:0]   sxv, syv;

  always_comb begin
    {stq, negx, negy, axq, ayq} = tagq;
    sxv = negx ? ({{2{axq[W-1]}}, axq} - {1'b0, qx})
               : ({{2{axq[W-1]}}, axq} + {1'b0, qx});
    syv = negy ? ({{2{ayq[W-1]}}, ayq} - {1'b0, qy})
               : ({{2{ayq[W-1]}}, ayq} + {1'b0, qy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq;
    end
    status <= stq;
    sx     <= (stq == segint_pkg::ST_HIT) ? sxv[W-1:0] : '0;
    sy     <= (stq == segint_pkg::ST_HIT) ? syv[W-1:0] : '0;
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("result strobe missing after fixed latency");

  a_zero_off_hit: assert property (@(posedge clk) disable iff (rst)
    (done && status != segint_pkg::ST_HIT) |-> (sx == '0 && sy == '0))
    else $error("point not zero without a hit");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(vq)) |-> 1'b0)
    else $error("result strobe without divider output");

endmodule
`default_nettype wire
